>>> rtl/lzd_pkg.sv
// Shared constants and types of the LZ stream decompressor.
// Used by lz_stream_decompressor; depends on nothing.
package lzd_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned LEN_BITS   = 24;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [LEN_BITS-1:0] LEN_MAX     = {LEN_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] RUN_BASE    = LEN_BITS'(15);
  localparam logic [BYTE_W-1:0]   EXT_STEP    = 8'd255;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_BUSY   = 3'd1,
    ST_DONE   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BADOFF = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CODE      = 3'd1,
    PH_LIT_EXT   = 3'd2,
    PH_LITERAL   = 3'd3,
    PH_MATCH_EXT = 3'd4,
    PH_OFFSET    = 3'd5
  } phase_e;

  // Work handed from the parse stage to the history stage
  typedef struct packed {
    logic                res;
    status_e             status;
    logic                last;
    logic                wr;
    logic                drain;
    logic [BYTE_W-1:0]   lit;
    logic [HIST_AW-1:0]  waddr;
  } s1_t;

endpackage

>>> rtl/lzd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lzd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lz_stream_decompressor.sv
// Top level of the LZ stream decompressor: token parser, history stage, output register.
// Depends on lzd_pkg and lzd_ram.
//
// channel | dir | tdata                                   | tuser    | tlast
// s_axis  | in  | [7:0] in_byte, [31:8] stream_length     | [1:0] cmd | -
// m_axis  | out | [7:0] out_byte                          | [2:0] status | last_of_stream
//
// One item per cycle unless m_axis stalls, including back-to-back overlapping drains.
// A result is loaded into the output register from the history stage after its item is
// accepted; the history RAM is read in the parse cycle and written from the history stage.
// While a stalled master side holds a result, items without a result keep passing; the
// first item with a result waits in the history stage and s_axis_tready drops.
// Reset clears all control state; the history RAM is not cleared.
module lz_stream_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] in_byte, [31:8] stream_length
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  localparam int unsigned AW = lzd_pkg::HIST_AW;
  localparam int unsigned LW = lzd_pkg::LEN_BITS;
  localparam int unsigned BW = lzd_pkg::BYTE_W;

  lzd_pkg::phase_e  phase_q, phase_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [LW-1:0]    prod_q, prod_d;
  logic [LW-1:0]    tgt_q, tgt_d;
  logic [LW-1:0]    acc_q, acc_d;
  logic [3:0]       nib_q, nib_d;
  logic [LW-1:0]    crem_q, crem_d;
  logic [AW-1:0]    dist_q, dist_d;

  logic             s1_valid_q;
  lzd_pkg::s1_t     s1_q, s1_d;
  logic             fwd_q, fwd_d;
  logic [BW-1:0]    fwd_data_q;

  logic             out_valid_q;
  logic [BW-1:0]    out_byte_q;
  lzd_pkg::status_e out_status_q;
  logic             out_last_q;

  logic             accept;
  logic             out_free;
  logic             s1_adv;
  logic [BW-1:0]    s1_byte;
  logic [BW-1:0]    ram_rdata;
  logic             ram_re;
  logic [AW-1:0]    raddr;

  lzd_pkg::cmd_e    cmd;
  logic [BW-1:0]    b;

  assign cmd = lzd_pkg::cmd_e'(s_axis_tuser);
  assign b   = s_axis_tdata[7:0];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_q.res || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign raddr         = wp_q - dist_q;

  // Parse stage
  always_comb begin
    logic [LW:0]    sum;
    logic [LW-1:0]  prod_inc;
    logic [LW-1:0]  left;
    logic [AW-1:0]  dist_new;
    logic           produce;

    phase_d  = phase_q;
    wp_d     = wp_q;
    prod_d   = prod_q;
    tgt_d    = tgt_q;
    acc_d    = acc_q;
    nib_d    = nib_q;
    crem_d   = crem_q;
    dist_d   = dist_q;
    ram_re   = 1'b0;
    produce  = 1'b0;
    s1_d     = '{res: 1'b0, status: lzd_pkg::ST_BYTE, last: 1'b0, wr: 1'b0,
                 drain: 1'b0, lit: '0, waddr: wp_q};
    sum      = '0;
    left     = tgt_q - prod_q;
    dist_new = {b, nib_q};
    prod_inc = prod_q + LW'(1);

    case (cmd)
      lzd_pkg::CMD_START: begin
        tgt_d   = s_axis_tdata[31:8];
        prod_d  = '0;
        acc_d   = '0;
        nib_d   = '0;
        crem_d  = '0;
        dist_d  = '0;
        phase_d = (s_axis_tdata[31:8] == '0) ? lzd_pkg::PH_IDLE : lzd_pkg::PH_CODE;
      end
      lzd_pkg::CMD_DRAIN: begin
        s1_d.res = 1'b1;
        if (crem_q == '0) begin
          s1_d.status = lzd_pkg::ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          s1_d.drain = 1'b1;
          crem_d     = crem_q - LW'(1);
          produce    = 1'b1;
        end
      end
      lzd_pkg::CMD_FEED: begin
        if (phase_q == lzd_pkg::PH_IDLE) begin
          s1_d.res    = 1'b1;
          s1_d.status = lzd_pkg::ST_DONE;
        end else if (crem_q != '0) begin
          s1_d.res    = 1'b1;
          s1_d.status = lzd_pkg::ST_BUSY;
        end else begin
          case (phase_q)
            lzd_pkg::PH_CODE: begin
              if (b == '0) begin
                acc_d   = lzd_pkg::RUN_BASE;
                phase_d = lzd_pkg::PH_LIT_EXT;
              end else if (b[7:4] == 4'd0) begin
                acc_d   = LW'(b);
                phase_d = lzd_pkg::PH_LITERAL;
              end else begin
                nib_d = b[7:4];
                if (b[3:0] == 4'd0) begin
                  acc_d   = lzd_pkg::RUN_BASE;
                  phase_d = lzd_pkg::PH_MATCH_EXT;
                end else begin
                  acc_d   = LW'(b[3:0]);
                  phase_d = lzd_pkg::PH_OFFSET;
                end
              end
            end
            lzd_pkg::PH_LIT_EXT, lzd_pkg::PH_MATCH_EXT: begin
              sum   = {1'b0, acc_q} + (LW+1)'((b == '0) ? lzd_pkg::EXT_STEP : b);
              acc_d = sum[LW] ? lzd_pkg::LEN_MAX : sum[LW-1:0];
              if (b != '0) begin
                phase_d = (phase_q == lzd_pkg::PH_LIT_EXT) ? lzd_pkg::PH_LITERAL
                                                           : lzd_pkg::PH_OFFSET;
              end
            end
            lzd_pkg::PH_LITERAL: begin
              if (acc_q > LW'(1)) begin
                acc_d = acc_q - LW'(1);
              end else begin
                acc_d   = '0;
                phase_d = lzd_pkg::PH_CODE;
              end
              s1_d.res = 1'b1;
              s1_d.lit = b;
              produce  = 1'b1;
            end
            lzd_pkg::PH_OFFSET: begin
              phase_d = lzd_pkg::PH_CODE;
              acc_d   = '0;
              if (dist_new == '0 || LW'(dist_new) > prod_q) begin
                s1_d.res    = 1'b1;
                s1_d.status = lzd_pkg::ST_BADOFF;
              end else begin
                dist_d = dist_new;
                crem_d = (acc_q < left) ? acc_q : left;
              end
            end
            default: begin
              phase_d     = lzd_pkg::PH_IDLE;
              s1_d.res    = 1'b1;
              s1_d.status = lzd_pkg::ST_DONE;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (produce) begin
      s1_d.wr = 1'b1;
      wp_d    = wp_q + AW'(1);
      prod_d  = prod_inc;
      if (prod_inc >= tgt_q) begin
        s1_d.last = 1'b1;
        phase_d   = lzd_pkg::PH_IDLE;
        crem_d    = '0;
        acc_d     = '0;
      end
    end

    if (!accept) begin
      ram_re = 1'b0;
    end
    fwd_d = ram_re && s1_valid_q && s1_q.wr && (s1_q.waddr == raddr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lzd_pkg::PH_IDLE;
      wp_q       <= '0;
      prod_q     <= '0;
      tgt_q      <= '0;
      acc_q      <= '0;
      nib_q      <= '0;
      crem_q     <= '0;
      dist_q     <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        wp_q    <= wp_d;
        prod_q  <= prod_d;
        tgt_q   <= tgt_d;
        acc_q   <= acc_d;
        nib_q   <= nib_d;
        crem_q  <= crem_d;
        dist_q  <= dist_d;
        fwd_q   <= fwd_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (fwd_d) begin
      fwd_data_q <= s1_byte;
    end
  end

  // History stage
  assign s1_byte = s1_q.drain ? (fwd_q ? fwd_data_q : ram_rdata) : s1_q.lit;

  lzd_ram #(
    .Width (BW),
    .Depth (lzd_pkg::HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (s1_adv && s1_q.wr),
    .waddr_i (s1_q.waddr),
    .wdata_i (s1_byte),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.res) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.res) begin
      out_byte_q   <= s1_byte;
      out_status_q <= s1_q.status;
      out_last_q   <= s1_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_active_short : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != lzd_pkg::PH_IDLE |-> prod_q < tgt_q)
    else $error("stream active with produced count at target");

  a_copy_in_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    crem_q != '0 |-> phase_q == lzd_pkg::PH_CODE)
    else $error("copy pending outside code phase");

  a_fwd_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_q && s1_valid_q) |-> s1_q.drain)
    else $error("forwarding marked on a non-drain item");

  a_accept_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item lost before history stage");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !accept)
    else $error("item accepted while history stage is held");

endmodule
